@@ sv/mvee_pkg.sv @@
`default_nettype none

package mvee_pkg;

    localparam int DW    = 50;   // divider quotient bits
    localparam int NTERM = 20;   // series terms
    localparam int KMAX  = 31;   // whole e^-1 factors

    localparam logic [20:0] HALF_STEP_RST = 21'd3277;
    localparam logic [28:0] EINV          = 29'd395007542;   // e^-1 in Q.30
    localparam logic [30:0] ONE30         = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] v0;
        logic signed [31:0] thr;
        logic               last;
        logic               sel;     // rate is zero
        logic               nsgn;    // numerator sign
        logic        [49:0] qm;      // quotient magnitude
        logic        [48:0] rs;      // zero rate increment magnitude
        logic               ezero;
        logic        [4:0]  k;
        logic        [15:0] u;
        logic        [31:0] e;
    } ctx_t;

    typedef struct packed {
        logic [46:0] term;
        logic [47:0] pos;
        logic [47:0] neg;
    } ser_t;

    typedef struct packed {
        logic [49:0] acc_n;
        logic [30:0] rem_n;
        logic [30:0] d_n;
        logic [49:0] acc_b;
        logic [30:0] rem_b;
        logic [30:0] d_b;
    } div_t;

endpackage

`default_nettype wire

@@ sv/membrane_voltage_exp_euler_step.sv @@
`default_nettype none

// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata neuron word, s_tlast last in step
// m       | out | m_tvalid/m_tready  | m_tdata voltage and fire flag, m_tlast end of step
// cfg     | in  | cfg_valid/cfg_ready| cfg_data half step
//
// One word enters per cycle while the output is not stalled.
// The pipeline holds two 50 stage restoring dividers, 20 series terms of
// four stages each and 31 stages of e^-1 products, plus seven stages of
// input, multiply, series result and output registers.
// Reset clears all valid bits and loads half step 3277.
// A stalled output freezes the whole pipeline; s_tready follows it.

module membrane_voltage_exp_euler_step
    import mvee_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // prev voltage, injected current, synaptic current, conductance sum,
    // reversal sum, capacitance, threshold, zero pad
    input  wire logic [223:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // membrane voltage, fired, zero pad
    output logic [39:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [20:0]  cfg_data
);

    localparam int NSTG   = DW + 4 * NTERM + KMAX + 7;

    logic [NSTG-1:0] vld_reg, vld_next;
    logic            adv;
    logic [20:0]     hs_reg;

    assign adv       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready  = adv;
    assign m_tvalid  = vld_reg[NSTG-1];
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hs_reg  <= HALF_STEP_RST;
        end
        else
        begin
            if (adv)
                vld_reg <= vld_next;
            if (cfg_valid)
                hs_reg <= cfg_data;
        end
    end

    // input stage
    logic signed [31:0] in_pv, in_ic, in_sc, in_rev, in_thr;
    logic        [30:0] in_g, in_cap, c_eff;
    logic signed [33:0] num;
    logic        [32:0] nmag;
    logic               sel_a;
    ctx_t               ctx_a_next;
    div_t               dv_a_next;

    assign in_pv  = s_tdata[31:0];
    assign in_ic  = s_tdata[63:32];
    assign in_sc  = s_tdata[95:64];
    assign in_g   = s_tdata[126:96];
    assign in_rev = s_tdata[158:127];
    assign in_cap = s_tdata[189:159];
    assign in_thr = s_tdata[221:190];

    always_comb
    begin
        num   = {{2{in_rev[31]}}, in_rev} + {{2{in_ic[31]}}, in_ic}
              + {{2{in_sc[31]}}, in_sc};
        nmag  = num[33] ? 33'(-num) : 33'(num);
        c_eff = (in_cap == '0) ? 31'd1 : in_cap;
        sel_a = {in_g, 16'h0} < {16'h0, c_eff};

        ctx_a_next       = '0;
        ctx_a_next.v0    = in_pv;
        ctx_a_next.thr   = in_thr;
        ctx_a_next.last  = s_tlast;
        ctx_a_next.sel   = sel_a;
        ctx_a_next.nsgn  = num[33];

        dv_a_next.acc_n = 50'({nmag, 16'h0});
        dv_a_next.rem_n = '0;
        dv_a_next.d_n   = sel_a ? c_eff : in_g;
        dv_a_next.acc_b = 50'({in_g, 16'h0});
        dv_a_next.rem_b = '0;
        dv_a_next.d_b   = c_eff;
    end

    ctx_t ctxd_reg [DW+1];
    div_t dv_reg   [DW+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctxd_reg[0] <= ctx_a_next;
            dv_reg[0]   <= dv_a_next;
        end
    end

    // restoring dividers, one quotient bit per stage
    for (genvar i = 1; i <= DW; i++) begin : g_div
        logic [31:0] tn, tb;
        logic        gen, geb;
        div_t        dv_next;

        always_comb
        begin
            tn  = {dv_reg[i-1].rem_n, dv_reg[i-1].acc_n[DW-1]};
            tb  = {dv_reg[i-1].rem_b, dv_reg[i-1].acc_b[DW-1]};
            gen = tn >= {1'b0, dv_reg[i-1].d_n};
            geb = tb >= {1'b0, dv_reg[i-1].d_b};
            dv_next       = dv_reg[i-1];
            dv_next.rem_n = gen ? 31'(tn - {1'b0, dv_reg[i-1].d_n}) : tn[30:0];
            dv_next.rem_b = geb ? 31'(tb - {1'b0, dv_reg[i-1].d_b}) : tb[30:0];
            dv_next.acc_n = {dv_reg[i-1].acc_n[DW-2:0], gen};
            dv_next.acc_b = {dv_reg[i-1].acc_b[DW-2:0], geb};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i]   <= dv_next;
                ctxd_reg[i] <= ctxd_reg[i-1];
            end
        end
    end

    // rate (numerator over capacitance when the rate is zero) times half step, split multiply
    ctx_t        ctx_c1_reg, ctx_c1_next, ctx_c2_reg, ctx_c2_next;
    logic [49:0] mop;
    logic [45:0] ph_reg, pl_reg;
    logic [70:0] prod;
    logic [71:0] prs;
    ser_t        ser_c2_reg, ser_c2_next;

    always_comb
    begin
        mop            = ctxd_reg[DW].sel ? dv_reg[DW].acc_n : dv_reg[DW].acc_b;
        ctx_c1_next    = ctxd_reg[DW];
        ctx_c1_next.qm = dv_reg[DW].acc_n;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_c1_reg <= ctx_c1_next;
            ph_reg     <= 46'(mop[49:25] * hs_reg);
            pl_reg     <= 46'(mop[24:0] * hs_reg);
        end
    end

    always_comb
    begin
        prod              = (71'(ph_reg) << 25) + 71'(pl_reg);
        prs               = 72'(prod) + 72'h8000;
        ctx_c2_next       = ctx_c1_reg;
        ctx_c2_next.rs    = (prs[71:64] != '0) ? 49'h100_0000_0000 : 49'(prs[63:16]);
        ctx_c2_next.ezero = prod[70:37] != '0;
        ctx_c2_next.k     = prod[36:32];
        ctx_c2_next.u     = prod[31:16];
        ser_c2_next.term  = 47'h4000_0000_0000;
        ser_c2_next.pos   = 48'h4000_0000_0000;
        ser_c2_next.neg   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_c2_reg <= ctx_c2_next;
            ser_c2_reg <= ser_c2_next;
        end
    end

    // exp(-u) series, four stages a term
    ctx_t ctxs4_reg [NTERM];
    ser_t sers4_reg [NTERM];

    for (genvar j = 0; j < NTERM; j++) begin : g_ser
        localparam int N = j + 1;
        localparam logic [45:0] RECIP = (N == 1) ? 46'd0 : 46'((64'd1 << 46) / N);

        ctx_t        ctx_in, ctx1_reg, ctx2_reg, ctx3_reg;
        ser_t        ser_in, ser1_reg, ser2_reg, ser3_reg, ser_next;
        logic [61:0] pr_reg;
        logic [45:0] tt_reg, tt2_reg, q0_reg, q0_next, cr, term_next, tsel;
        logic [45:0] pp_reg [4];
        logic [91:0] psum;
        logic        inc;

        if (j == 0) begin : g_head
            assign ctx_in = ctx_c2_reg;
            assign ser_in = ser_c2_reg;
        end
        else begin : g_link
            assign ctx_in = ctxs4_reg[j-1];
            assign ser_in = sers4_reg[j-1];
        end

        assign tsel = pr_reg[61:16];

        always_comb
        begin
            psum = (92'(pp_reg[0]) << 46) + ((92'(pp_reg[1]) + 92'(pp_reg[2])) << 23)
                 + 92'(pp_reg[3]);
            q0_next   = (N == 1) ? tt_reg : psum[91:46];
            cr        = tt2_reg - 46'(q0_reg * 46'(N));
            inc       = cr >= 46'(N);
            term_next = q0_reg + 46'(inc);
            ser_next      = ser3_reg;
            ser_next.term = 47'(term_next);
            if (N % 2 == 1)
                ser_next.neg = ser3_reg.neg + 48'(term_next);
            else
                ser_next.pos = ser3_reg.pos + 48'(term_next);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pr_reg    <= 62'(63'(ser_in.term) * 63'(ctx_in.u));
                ctx1_reg  <= ctx_in;
                ser1_reg  <= ser_in;
                tt_reg    <= tsel;
                pp_reg[0] <= 46'(tsel[45:23] * RECIP[45:23]);
                pp_reg[1] <= 46'(tsel[45:23] * RECIP[22:0]);
                pp_reg[2] <= 46'(tsel[22:0] * RECIP[45:23]);
                pp_reg[3] <= 46'(tsel[22:0] * RECIP[22:0]);
                ctx2_reg  <= ctx1_reg;
                ser2_reg  <= ser1_reg;
                q0_reg    <= q0_next;
                tt2_reg   <= tt_reg;
                ctx3_reg  <= ctx2_reg;
                ser3_reg  <= ser2_reg;
                ctxs4_reg[j] <= ctx3_reg;
                sers4_reg[j] <= ser_next;
            end
        end
    end

    // series result, then whole e^-1 factors
    ctx_t        ctxx_reg [KMAX+1];
    ctx_t        ctx_e0_next;
    logic [47:0] sdiff;

    always_comb
    begin
        sdiff         = sers4_reg[NTERM-1].pos - sers4_reg[NTERM-1].neg;
        ctx_e0_next   = ctxs4_reg[NTERM-1];
        ctx_e0_next.e = (sers4_reg[NTERM-1].neg > sers4_reg[NTERM-1].pos) ? 32'd0
                      : 32'((sdiff + 48'h8000) >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ctxx_reg[0] <= ctx_e0_next;
    end

    for (genvar i = 0; i < KMAX; i++) begin : g_exp
        logic [63:0] ep;
        ctx_t        ctx_next;

        always_comb
        begin
            ep       = 64'(ctxx_reg[i].e) * 64'(EINV) + 64'h2000_0000;
            ctx_next = ctxx_reg[i];
            if (5'(i) < ctxx_reg[i].k)
                ctx_next.e = 32'(ep >> 30);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                ctxx_reg[i+1] <= ctx_next;
        end
    end

    // products, sum, saturate
    ctx_t               ctx_f1_reg, ctx_f2_reg, ctx_f3_reg, cf;
    logic        [30:0] ef, w2;
    logic        [31:0] v0mag;
    logic        [62:0] p1_reg;
    logic        [55:0] p2h_reg, p2l_reg;
    logic        [32:0] p1r;
    logic        [81:0] s2;
    logic        [40:0] r2;
    logic signed [51:0] a1, a2, a3, vsum_next, vsum_reg;
    logic signed [31:0] vsat, out_v_reg;
    logic               fired_reg, last_reg;

    always_comb
    begin
        cf    = ctxx_reg[KMAX];
        ef    = cf.ezero ? 31'd0 : ((cf.e > 32'(ONE30)) ? ONE30 : 31'(cf.e));
        w2    = ONE30 - ef;
        v0mag = cf.v0[31] ? 32'(-cf.v0) : 32'(cf.v0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_f1_reg <= cf;
            p1_reg     <= 63'(v0mag * ef);
            p2h_reg    <= 56'(cf.qm[49:25] * w2);
            p2l_reg    <= 56'(cf.qm[24:0] * w2);
        end
    end

    always_comb
    begin
        p1r = 33'((64'(p1_reg) + 64'h2000_0000) >> 30);
        s2  = (82'(p2h_reg) << 25) + 82'(p2l_reg) + 82'h2000_0000;
        r2  = (s2[81:64] != '0) ? 41'h100_0000_0000 : 41'(s2[63:30]);
        a1  = $signed(52'(p1r));
        a2  = $signed(52'(r2));
        a3  = $signed(52'(ctx_f1_reg.rs));
        if (ctx_f1_reg.v0[31])
            a1 = -a1;
        if (ctx_f1_reg.nsgn)
        begin
            a2 = -a2;
            a3 = -a3;
        end
        vsum_next = ctx_f1_reg.sel ? (52'(ctx_f1_reg.v0) + a3) : (a1 + a2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_f2_reg <= ctx_f1_reg;
            vsum_reg   <= vsum_next;
        end
    end

    always_comb
    begin
        if (vsum_reg > 52'sh7FFF_FFFF)
            vsat = 32'sh7FFF_FFFF;
        else if (vsum_reg < -52'sh8000_0000)
            vsat = 32'sh8000_0000;
        else
            vsat = 32'(vsum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_f3_reg <= ctx_f2_reg;
            out_v_reg  <= vsat;
            fired_reg  <= (ctx_f2_reg.v0 <= ctx_f2_reg.thr) && (vsat > ctx_f2_reg.thr);
            last_reg   <= ctx_f2_reg.last;
        end
    end

    assign m_tdata = {7'd0, fired_reg, out_v_reg};
    assign m_tlast = last_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (dv_reg[0].d_n != '0 && dv_reg[0].d_b != '0))
        else $error("zero divisor entered divider");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DW] |-> (dv_reg[DW].rem_n < dv_reg[DW].d_n
                         && dv_reg[DW].rem_b < dv_reg[DW].d_b))
        else $error("divider remainder out of range");

    a_sel_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DW] && ctxd_reg[DW].sel) |-> (dv_reg[DW].acc_b == '0))
        else $error("zero rate flag disagrees with rate quotient");

    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NSTG-1] && fired_reg) |->
            (out_v_reg > ctx_f3_reg.thr && ctx_f3_reg.v0 <= ctx_f3_reg.thr))
        else $error("fire flag without threshold crossing");

endmodule

`default_nettype wire
